@@ rtl/core/icfg_pkg.sv @@
package icfg_pkg;

  localparam int unsigned NumSlots = 28;
  localparam int unsigned SlotW    = 5;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_ID_WORD    = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_CLASS_WORD = 1'b1;

  localparam logic [31:0] ID_WORD_RESET    = 32'h24CB_8086;
  localparam logic [15:0] CLASS_WORD_RESET = 16'h0101;

  localparam logic [7:0] ADDR_BM_LOW  = 8'h20;
  localparam logic [7:0] ADDR_BM_HIGH = 8'h21;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] slot;
  } slot_t;

  typedef struct packed {
    logic             we;
    logic [SlotW-1:0] slot;
    logic [7:0]       data;
  } wr_req_t;

  // Writable bytes are held in a small register file; each one maps to a slot.
  function automatic slot_t slot_lookup(input logic [7:0] addr);
    slot_t s;
    s.hit = 1'b1;
    unique case (addr)
      8'h04: s.slot = 5'd0;
      8'h07: s.slot = 5'd1;
      8'h09: s.slot = 5'd2;
      8'h10: s.slot = 5'd3;
      8'h11: s.slot = 5'd4;
      8'h14: s.slot = 5'd5;
      8'h15: s.slot = 5'd6;
      8'h18: s.slot = 5'd7;
      8'h19: s.slot = 5'd8;
      8'h1c: s.slot = 5'd9;
      8'h1d: s.slot = 5'd10;
      8'h20: s.slot = 5'd11;
      8'h2c: s.slot = 5'd12;
      8'h2d: s.slot = 5'd13;
      8'h2e: s.slot = 5'd14;
      8'h2f: s.slot = 5'd15;
      8'h3c: s.slot = 5'd16;
      8'h40: s.slot = 5'd17;
      8'h41: s.slot = 5'd18;
      8'h42: s.slot = 5'd19;
      8'h43: s.slot = 5'd20;
      8'h44: s.slot = 5'd21;
      8'h48: s.slot = 5'd22;
      8'h4a: s.slot = 5'd23;
      8'h4b: s.slot = 5'd24;
      8'h54: s.slot = 5'd25;
      8'h55: s.slot = 5'd26;
      8'h56: s.slot = 5'd27;
      default: begin
        s.hit  = 1'b0;
        s.slot = '0;
      end
    endcase
    return s;
  endfunction

  function automatic logic [7:0] slot_reset(input logic [SlotW-1:0] slot);
    logic [7:0] v;
    unique case (slot)
      5'd1:                      v = 8'h02;
      5'd3, 5'd5, 5'd7, 5'd9,
      5'd11:                     v = 8'h01;
      default:                   v = 8'h00;
    endcase
    return v;
  endfunction

  // Bytes that are neither writable nor taken from configuration.
  function automatic logic [7:0] const_byte(input logic [7:0] addr);
    logic [7:0] v;
    unique case (addr)
      8'h06:   v = 8'h80;
      8'h3d:   v = 8'h01;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/icfg_if.sv @@
interface icfg_req_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  address;
  logic [31:0] write_data;
  logic [2:0]  byte_count;

  modport source (output valid, action, address, write_data, byte_count, input ready);
  modport sink (input valid, action, address, write_data, byte_count, output ready);
endinterface

interface icfg_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic [15:0] bm_base;
  logic        bm_enable;

  modport source (output valid, read_data, bm_base, bm_enable, input ready);
  modport sink (input valid, read_data, bm_base, bm_enable, output ready);
endinterface

@@ rtl/core/icfg_byte_unit.sv @@
module icfg_byte_unit (
  input  logic [7:0]  addr,
  input  logic [7:0]  wbyte,
  input  logic [7:0]  cur,
  input  logic        hit,
  input  logic [31:0] id_word,
  input  logic [15:0] class_word,
  output logic        wen,
  output logic [7:0]  wval,
  output logic [7:0]  rbyte
);
  import icfg_pkg::*;

  always_comb begin
    wen  = 1'b1;
    wval = wbyte;
    unique case (addr)
      8'h04:               wval = wbyte & 8'h07;
      8'h07:               wval = (wbyte & 8'h28) | 8'h02;
      8'h09:               wval = (wbyte & 8'h1f) | 8'h80;
      8'h10, 8'h18:        wval = (wbyte & 8'hf8) | 8'h01;
      8'h14, 8'h1c:        wval = (wbyte & 8'hfc) | 8'h01;
      8'h20:               wval = (wbyte & 8'hf0) | 8'h01;
      8'h2c, 8'h2d, 8'h2e,
      8'h2f:               wen  = (cur == 8'h00);
      8'h41, 8'h43:        wval = wbyte & 8'hf3;
      8'h48, 8'h56:        wval = wbyte & 8'h0f;
      8'h4a, 8'h4b:        wval = wbyte & 8'h33;
      8'h55:               wval = wbyte & 8'hf4;
      8'h11, 8'h15, 8'h19, 8'h1d, 8'h3c, 8'h40, 8'h42, 8'h44,
      8'h54:               wval = wbyte;
      default:             wen  = 1'b0;
    endcase
  end

  always_comb begin
    priority if (addr <= 8'h03) begin
      rbyte = 8'(id_word >> {addr[1:0], 3'b000});
    end else if (addr == 8'h0a) begin
      rbyte = class_word[7:0];
    end else if (addr == 8'h0b) begin
      rbyte = class_word[15:8];
    end else if (hit) begin
      rbyte = cur;
    end else begin
      rbyte = const_byte(addr);
    end
  end

endmodule

@@ rtl/core/icfg_store.sv @@
module icfg_store (
  input  logic                       clk,
  input  logic                       rst,
  input  icfg_pkg::wr_req_t          wr,
  input  logic [icfg_pkg::SlotW-1:0] rd_slot,
  output logic [7:0]                 rd_data,
  output logic [7:0]                 cmd_byte,
  output logic [7:0]                 bm_low_byte
);
  import icfg_pkg::*;

  localparam slot_t CmdSlot = slot_lookup(8'h04);
  localparam slot_t BmSlot  = slot_lookup(ADDR_BM_LOW);

  logic [7:0] regs [NumSlots];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumSlots; i++) begin
        regs[i] <= slot_reset(SlotW'(i));
      end
    end else if (wr.we) begin
      regs[wr.slot] <= wr.data;
    end
  end

  assign rd_data     = regs[rd_slot];
  assign cmd_byte    = regs[CmdSlot.slot];
  assign bm_low_byte = regs[BmSlot.slot];

endmodule

@@ rtl/core/ide_pci_config_space_masked_write_top.sv @@
// Each accepted access handles N bytes, where N is byte_count capped at four and at
// 0x100 minus the address: one byte per cycle through the single byte lane unit, then
// the result is registered once the output register is empty or being read.
// A new request is taken only once the last result is in the output register.
// Reset (rst, synchronous) restores the configuration bytes and registers to their
// power-up values and empties the result register; no clearing pass is needed.
module ide_pci_config_space_masked_write_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [icfg_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [icfg_pkg::CfgDataW-1:0] cfg_wdata,
  icfg_req_if.sink                      req,
  icfg_rsp_if.source                    rsp
);
  import icfg_pkg::*;

  state_t      state, state_next;
  logic [31:0] id_word;
  logic [15:0] class_word;
  logic        act;
  logic [7:0]  base;
  logic [31:0] wdata;
  logic [2:0]  cnt;
  logic [2:0]  idx, idx_next;
  logic [31:0] rdata, rdata_next;
  logic        out_valid;
  logic [31:0] out_rdata;
  logic [15:0] out_bm_base;
  logic        out_bm_enable;

  logic [8:0]  addr_full;
  logic [7:0]  addr;
  slot_t       lookup;
  logic [7:0]  cur, wbyte, wval, rbyte, cmd_byte, bm_low_byte;
  logic        wen;
  wr_req_t     wr;
  logic        accept, load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_word    <= ID_WORD_RESET;
      class_word <= CLASS_WORD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ID_WORD:    id_word    <= cfg_wdata;
        CFG_CLASS_WORD: class_word <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);

  assign addr_full = 9'(base) + 9'(idx);
  assign addr      = addr_full[7:0];
  assign lookup    = slot_lookup(addr);
  assign wbyte     = 8'(wdata >> {idx[1:0], 3'b000});

  icfg_byte_unit u_byte (
    .addr       (addr),
    .wbyte      (wbyte),
    .cur        (cur),
    .hit        (lookup.hit),
    .id_word    (id_word),
    .class_word (class_word),
    .wen        (wen),
    .wval       (wval),
    .rbyte      (rbyte)
  );

  always_comb begin
    wr.we   = (state == ST_RUN) && !addr_full[8] && act && wen && lookup.hit;
    wr.slot = lookup.slot;
    wr.data = wval;
  end

  icfg_store u_store (
    .clk         (clk),
    .rst         (rst),
    .wr          (wr),
    .rd_slot     (lookup.slot),
    .rd_data     (cur),
    .cmd_byte    (cmd_byte),
    .bm_low_byte (bm_low_byte)
  );

  always_comb begin
    state_next = state;
    idx_next   = idx;
    rdata_next = rdata;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          idx_next   = '0;
          rdata_next = '0;
          if (req.byte_count == 3'd0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (addr_full[8]) begin
          state_next = ST_DONE;
        end else begin
          if (!act) begin
            rdata_next = rdata | (32'(rbyte) << {idx[1:0], 3'b000});
          end
          idx_next = idx + 3'd1;
          if (idx + 3'd1 == cnt) begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx   <= idx_next;
    rdata <= rdata_next;
    if (accept) begin
      act   <= req.action;
      base  <= req.address;
      wdata <= req.write_data;
      cnt   <= (req.byte_count > 3'd4) ? 3'd4 : req.byte_count;
    end
    if (load_out) begin
      out_rdata     <= act ? 32'd0 : rdata;
      out_bm_base   <= {const_byte(ADDR_BM_HIGH), bm_low_byte & 8'hfe};
      out_bm_enable <= cmd_byte[2];
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_rdata;
  assign rsp.bm_base   = out_bm_base;
  assign rsp.bm_enable = out_bm_enable;

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_RUN |-> idx < cnt)
    else $error("byte index ran past the access length");

  a_write_only_in_write: assert property (@(posedge clk) disable iff (rst)
    wr.we |-> (state == ST_RUN) && act)
    else $error("store written outside a write access");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("accepted item did not start");

  a_hold_full_output: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && out_valid && !rsp.ready |=> state == ST_DONE && out_valid)
    else $error("result dropped while output register was full");

endmodule
